@@ rtl/core/next_permutation_assert.svh @@
`ifndef NEXT_PERMUTATION_ASSERT_SVH
`define NEXT_PERMUTATION_ASSERT_SVH

// same-cycle implication, checked on i_clk outside reset
`define NP_ASSERT_IMPL(label, a, c) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("next_permutation check failed");

// next-cycle implication
`define NP_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("next_permutation check failed");

`endif

@@ rtl/core/np_pkg.sv @@
package np_pkg;

    localparam int MAX_LEN = 8;
    localparam int ELEM_W  = 16;
    localparam int LEN_W   = 4;
    localparam int IDX_W   = $clog2(MAX_LEN);

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef t_elem [MAX_LEN-1:0] t_elem_vec;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        t_elem elem_0;
        t_elem elem_1;
        t_elem elem_2;
        t_elem elem_3;
        t_elem elem_4;
        t_elem elem_5;
        t_elem elem_6;
        t_elem elem_7;
    } t_perm_in;

    typedef struct packed {
        t_elem out_0;
        t_elem out_1;
        t_elem out_2;
        t_elem out_3;
        t_elem out_4;
        t_elem out_5;
        t_elem out_6;
        t_elem out_7;
        logic  wrapped;
    } t_perm_out;

    // pivot and successor search results handed to the reorder stages
    typedef struct packed {
        logic               valid;
        logic               short_vec;
        logic               found;
        logic [IDX_W-1:0]   pivot;
        logic [IDX_W-1:0]   lo;
        logic [IDX_W-1:0]   hi;
        logic [MAX_LEN-1:0] gt;
    } t_front;

    function automatic t_elem_vec to_vec(input t_perm_in d);
        t_elem_vec v;
        v[0] = d.elem_0;
        v[1] = d.elem_1;
        v[2] = d.elem_2;
        v[3] = d.elem_3;
        v[4] = d.elem_4;
        v[5] = d.elem_5;
        v[6] = d.elem_6;
        v[7] = d.elem_7;
        return v;
    endfunction

    function automatic t_perm_out to_out(input t_elem_vec v, input logic w);
        t_perm_out o;
        o.out_0   = v[0];
        o.out_1   = v[1];
        o.out_2   = v[2];
        o.out_3   = v[3];
        o.out_4   = v[4];
        o.out_5   = v[5];
        o.out_6   = v[6];
        o.out_7   = v[7];
        o.wrapped = w;
        return o;
    endfunction

endpackage

@@ rtl/core/np_front.sv @@
module np_front import np_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_perm_in  i_in,
    output t_front    o_front,
    output t_elem_vec o_vec
);

    // stage 1: saturated length and neighbor compares
    logic               r_s1_valid;
    t_elem_vec          r_s1_vec;
    logic [LEN_W-1:0]   r_s1_n;
    logic [MAX_LEN-1:0] r_s1_asc;

    t_elem_vec          n_s1_vec;
    logic [LEN_W-1:0]   n_s1_n;
    logic [MAX_LEN-1:0] n_s1_asc;

    always_comb begin
        n_s1_vec = to_vec(i_in);
        n_s1_n   = (i_in.length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : i_in.length;
        n_s1_asc = '0;
        for (int i = 1; i < MAX_LEN; i++) begin
            n_s1_asc[i] = (LEN_W'(i) < n_s1_n) && (n_s1_vec[i-1] < n_s1_vec[i]);
        end
    end

    // stage 2: rightmost pivot
    logic               r_s2_valid;
    t_elem_vec          r_s2_vec;
    logic [LEN_W-1:0]   r_s2_n;
    logic               r_s2_found;
    logic [IDX_W-1:0]   r_s2_pivot;
    t_elem              r_s2_pv;

    logic               n_s2_found;
    logic [IDX_W-1:0]   n_s2_pivot;

    always_comb begin
        n_s2_found = 1'b0;
        n_s2_pivot = '0;
        for (int i = 1; i < MAX_LEN; i++) begin
            if (r_s1_asc[i]) begin
                n_s2_found = 1'b1;
                n_s2_pivot = IDX_W'(i - 1);
            end
        end
    end

    // stage 3: positions right of the pivot holding a larger value
    t_front             r_s3;
    t_elem_vec          r_s3_vec;
    t_front             n_s3;

    always_comb begin
        n_s3           = '0;
        n_s3.valid     = r_s2_valid;
        n_s3.short_vec = (r_s2_n < LEN_W'(2));
        n_s3.found     = r_s2_found;
        n_s3.pivot     = r_s2_pivot;
        n_s3.lo        = r_s2_found ? (r_s2_pivot + IDX_W'(1)) : '0;
        n_s3.hi        = IDX_W'(r_s2_n - LEN_W'(1));
        for (int k = 0; k < MAX_LEN; k++) begin
            n_s3.gt[k] = (LEN_W'(k) < r_s2_n) && (IDX_W'(k) > r_s2_pivot)
                         && (r_s2_vec[k] > r_s2_pv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_vec       <= n_s1_vec;
        r_s1_n         <= n_s1_n;
        r_s1_asc       <= n_s1_asc;
        r_s2_vec       <= r_s1_vec;
        r_s2_n         <= r_s1_n;
        r_s2_found     <= n_s2_found;
        r_s2_pivot     <= n_s2_pivot;
        r_s2_pv        <= r_s1_vec[n_s2_pivot];
        r_s3.short_vec <= n_s3.short_vec;
        r_s3.found     <= n_s3.found;
        r_s3.pivot     <= n_s3.pivot;
        r_s3.lo        <= n_s3.lo;
        r_s3.hi        <= n_s3.hi;
        r_s3.gt        <= n_s3.gt;
        r_s3_vec       <= r_s2_vec;
        if (!i_rst_n) begin
            r_s3.valid <= 1'b0;
        end else begin
            r_s3.valid <= n_s3.valid;
        end
    end

    assign o_front = r_s3;
    assign o_vec   = r_s3_vec;

endmodule

@@ rtl/core/next_permutation.sv @@
// next_permutation: next lexicographically greater arrangement of up to
// eight signed 16-bit elements, equal elements handled.
//
// Input: raise start for one cycle with i_in (length and elem_0..elem_7).
// busy is always low, so a transaction can be issued on every clock.
// Output: o_valid pulses for exactly one cycle with o_out; the receiver
// must take it then, it cannot hold results off.
// Pipeline: a transaction accepted on start passes five register stages
// (compare, pivot search, successor compare, swap, span reversal) before
// o_valid rises with its result. Throughput: one per cycle.
// A non-increasing vector comes back sorted ascending with wrapped set;
// lengths below two and positions past the length pass through; a length
// above eight is taken as eight.
// Reset (synchronous, active low) drops every in-flight transaction; no
// result appears for them.
module next_permutation import np_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_perm_in  i_in,
    output logic      busy,
    output logic      o_valid,
    output t_perm_out o_out
);

`include "next_permutation_assert.svh"

    t_front    w_front;
    t_elem_vec w_vec;

    np_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_in    (i_in),
        .o_front (w_front),
        .o_vec   (w_vec)
    );

    assign busy = 1'b0;

    // stage 4: rightmost successor and swap with the pivot
    logic             r_s4_valid;
    t_elem_vec        r_s4_vec;
    logic             r_s4_rev;
    logic             r_s4_wrap;
    logic [IDX_W-1:0] r_s4_lo;
    logic [IDX_W-1:0] r_s4_hi;

    logic [IDX_W-1:0] n_j;
    t_elem_vec        n_s4_vec;

    always_comb begin
        n_j = '0;
        for (int k = 0; k < MAX_LEN; k++) begin
            if (w_front.gt[k]) begin
                n_j = IDX_W'(k);
            end
        end
        n_s4_vec = w_vec;
        if (w_front.found && !w_front.short_vec) begin
            n_s4_vec[w_front.pivot] = w_vec[n_j];
            n_s4_vec[n_j]           = w_vec[w_front.pivot];
        end
    end

    // stage 5: reverse the span lo..hi
    t_elem_vec        n_s5_vec;
    logic [IDX_W:0]   n_sum;

    always_comb begin
        n_sum    = {1'b0, r_s4_lo} + {1'b0, r_s4_hi};
        n_s5_vec = r_s4_vec;
        for (int p = 0; p < MAX_LEN; p++) begin
            if (r_s4_rev && (IDX_W'(p) >= r_s4_lo) && (IDX_W'(p) <= r_s4_hi)) begin
                n_s5_vec[p] = r_s4_vec[IDX_W'(n_sum - (IDX_W+1)'(p))];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            r_s4_valid <= w_front.valid;
            o_valid    <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_vec  <= n_s4_vec;
        r_s4_rev  <= !w_front.short_vec;
        r_s4_wrap <= !w_front.short_vec && !w_front.found;
        r_s4_lo   <= w_front.lo;
        r_s4_hi   <= w_front.hi;
        o_out     <= to_out(n_s5_vec, r_s4_wrap);
    end

    `NP_ASSERT_IMPL(a_latency, start && !busy, ##5 o_valid)
    `NP_ASSERT_IMPL(a_no_spurious, o_valid, $past(start, 5))
    `NP_ASSERT_IMPL(a_successor, w_front.valid && w_front.found && !w_front.short_vec,
        w_front.gt != '0)
    `NP_ASSERT_NEXT(a_wrap_span, w_front.valid && !w_front.short_vec && !w_front.found,
        r_s4_wrap && r_s4_lo == '0)

endmodule
